### sv/bza_pkg.sv
// ----------------------------------------------------------------------------
// bza_pkg
// Shared codes for the bitmap zone allocator: request types, status codes,
// configuration register indexes and map geometry.
// ----------------------------------------------------------------------------
package bza_pkg;

  localparam int unsigned BitsPerMapBlock = 8192;
  localparam int unsigned WordsPerBlock   = BitsPerMapBlock / 32;
  localparam int unsigned BlockWordShift  = $clog2(WordsPerBlock);
  localparam int unsigned BlockBitShift   = $clog2(BitsPerMapBlock);

  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqCount = 2'd2;
  localparam logic [1:0] ReqWrite = 2'd3;

  localparam logic [2:0] StOk           = 3'd0;
  localparam logic [2:0] StNotData      = 3'd1;
  localparam logic [2:0] StNoMap        = 3'd2;
  localparam logic [2:0] StAlreadyClear = 3'd3;
  localparam logic [2:0] StFull         = 3'd4;
  localparam logic [2:0] StRange        = 3'd5;

  localparam logic [1:0] CfgFirstDataZone = 2'd0;
  localparam logic [1:0] CfgNumZones      = 2'd1;
  localparam logic [1:0] CfgMapBlocksUsed = 2'd2;
  localparam logic [1:0] CfgLogZoneSize   = 2'd3;

endpackage

### sv/bitmap_zone_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_zone_allocator_unit
// Free-zone bitmap allocator: allocate, free, count and word load over a
// single-port-read bitmap memory scanned by a small sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result word
// appears on the result ports with done_o for a single cycle and cannot be
// held off. A word write finishes in the cycle after it is taken; a free
// checks the block in S_FREE_CHK, where a rejected free ends, and otherwise
// reads the map word and clears the bit in S_FREE_WR. Allocate and count
// walk the bitmap one 32-bit word per cycle through the memory's single read
// port; count stops at the lesser of num_zones + 1 - first_data_zone and the
// bits held by the map blocks in use. After reset the memory is cleared one
// word per cycle; busy stays high meanwhile. Configuration writes are taken
// in every cycle.
module bitmap_zone_allocator_unit #(
  parameter int unsigned MAP_BLOCKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [19:0] block_number_i,
  input  logic [10:0] word_index_i,
  input  logic [31:0] word_value_i,
  output logic        done_o,
  output logic [19:0] allocated_block_o,
  output logic [2:0]  status_o,
  output logic [31:0] free_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned TotalWords = MAP_BLOCKS * bza_pkg::WordsPerBlock;
  localparam int unsigned AW = $clog2(TotalWords);
  localparam int unsigned BW = $clog2(MAP_BLOCKS + 1);
  localparam int unsigned CW = BW + bza_pkg::BlockWordShift;
  localparam int unsigned PW = AW + 5;

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_ALLOC     = 9'b000000100,
    S_ALLOC_CHK = 9'b000001000,
    S_FREE_CHK  = 9'b000010000,
    S_FREE_WR   = 9'b000100000,
    S_CNT_LIM   = 9'b001000000,
    S_COUNT     = 9'b010000000,
    S_CNT_FIN   = 9'b100000000
  } state_e;

  function automatic logic [4:0] first_zero(input logic [31:0] v);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [5:0] ones32(input logic [31:0] v);
    logic [31:0] t;
    t = v - ((v >> 1) & 32'h5555_5555);
    t = (t & 32'h3333_3333) + ((t >> 2) & 32'h3333_3333);
    t = (t + (t >> 4)) & 32'h0f0f_0f0f;
    t = t + (t >> 8);
    t = t + (t >> 16);
    return t[5:0];
  endfunction

  // configuration
  logic [19:0] first_data_zone_q, num_zones_q;
  logic [3:0]  map_blocks_used_q, log_zone_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_data_zone_q <= '0;
      num_zones_q       <= '0;
      map_blocks_used_q <= '0;
      log_zone_size_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        bza_pkg::CfgFirstDataZone: first_data_zone_q <= cfg_data_i[19:0];
        bza_pkg::CfgNumZones:      num_zones_q       <= cfg_data_i[19:0];
        bza_pkg::CfgMapBlocksUsed: map_blocks_used_q <= cfg_data_i[3:0];
        bza_pkg::CfgLogZoneSize:   log_zone_size_q   <= cfg_data_i[3:0];
      endcase
    end
  end

  logic [BW-1:0] blocks_in_use;
  logic [CW-1:0] nwords;
  logic [21:0]   stored_bits;

  assign blocks_in_use = (32'(map_blocks_used_q) > MAP_BLOCKS) ? BW'(MAP_BLOCKS)
                                                               : BW'(map_blocks_used_q);
  assign nwords      = {blocks_in_use, {bza_pkg::BlockWordShift{1'b0}}};
  assign stored_bits = 22'({blocks_in_use, {bza_pkg::BlockBitShift{1'b0}}});

  // bitmap memory
  logic [31:0]   mem_q [TotalWords];
  logic [31:0]   rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  // sequencer
  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          rd_valid_q, rd_valid_d;
  logic          done_q, done_d;

  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [31:0]   mask_q, mask_d;
  logic [20:0]   limit_q, limit_d;
  logic [20:0]   sum_q, sum_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [19:0]   blk_q, blk_d;
  logic [AW-1:0] faddr_q, faddr_d;
  logic [4:0]    fbit_q, fbit_d;
  logic [19:0]   res_blk_q, res_blk_d;
  logic [2:0]    res_st_q, res_st_d;
  logic [31:0]   res_cnt_q, res_cnt_d;

  logic [4:0]  fz;
  logic [21:0] base, rem, t1, lim_top, lim_raw;
  logic [20:0] zone;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    scan_d     = scan_q;
    rd_valid_d = 1'b0;
    done_d     = 1'b0;
    rd_addr_d  = rd_addr_q;
    mask_d     = mask_q;
    limit_d    = limit_q;
    sum_d      = sum_q;
    pos_d      = pos_q;
    blk_d      = blk_q;
    faddr_d    = faddr_q;
    fbit_d     = fbit_q;
    res_blk_d  = res_blk_q;
    res_st_d   = res_st_q;
    res_cnt_d  = res_cnt_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    fz      = first_zero(rdata_q);
    base    = 22'({scan_q, 5'b0});
    rem     = 22'(limit_q) - base;
    t1      = 22'(pos_q) + 22'(first_data_zone_q) - 22'd1;
    zone    = 21'(blk_q) - 21'(first_data_zone_q) + 21'd1;
    lim_top = 22'(num_zones_q) + 22'd1;
    lim_raw = (lim_top > 22'(first_data_zone_q)) ? lim_top - 22'(first_data_zone_q) : '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(TotalWords - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          res_blk_d = '0;
          res_st_d  = bza_pkg::StOk;
          res_cnt_d = '0;
          unique case (req_type_i)
            bza_pkg::ReqAlloc: begin
              scan_d  = '0;
              state_d = S_ALLOC;
            end
            bza_pkg::ReqFree: begin
              blk_d   = block_number_i;
              state_d = S_FREE_CHK;
            end
            bza_pkg::ReqCount: state_d = S_CNT_LIM;
            bza_pkg::ReqWrite: begin
              if (32'(word_index_i) < TotalWords) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(word_index_i);
                mem_wdata = word_value_i;
              end
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (rd_valid_q && (rdata_q != '1)) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q;
          mem_wdata = rdata_q | (32'd1 << fz);
          pos_d     = {rd_addr_q, fz};
          state_d   = S_ALLOC_CHK;
        end else if (scan_q < nwords) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_q[AW-1:0];
          rd_addr_d  = scan_q[AW-1:0];
          rd_valid_d = 1'b1;
          scan_d     = scan_q + CW'(1);
        end else begin
          res_st_d = bza_pkg::StFull;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_ALLOC_CHK: begin
        if ((pos_q == '0) || (t1 >= 22'(num_zones_q))) begin
          res_st_d = bza_pkg::StRange;
        end else begin
          res_blk_d = t1[19:0];
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_FREE_CHK: begin
        if ((blk_q < first_data_zone_q) || (blk_q >= num_zones_q)) begin
          res_st_d = bza_pkg::StNotData;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (zone[20:13] >= 8'(blocks_in_use)) begin
          res_st_d = bza_pkg::StNoMap;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(zone[20:5]);
          faddr_d   = AW'(zone[20:5]);
          fbit_d    = zone[4:0];
          state_d   = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        if (!rdata_q[fbit_q]) begin
          res_st_d = bza_pkg::StAlreadyClear;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = faddr_q;
          mem_wdata = rdata_q & ~(32'd1 << fbit_q);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_CNT_LIM: begin
        limit_d = (lim_raw > stored_bits) ? stored_bits[20:0] : lim_raw[20:0];
        scan_d  = '0;
        sum_d   = '0;
        state_d = S_COUNT;
      end
      S_COUNT: begin
        if (rd_valid_q) sum_d = sum_q + 21'(ones32(~rdata_q & mask_q));
        if (base < 22'(limit_q)) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_q[AW-1:0];
          rd_valid_d = 1'b1;
          scan_d     = scan_q + CW'(1);
          mask_d     = (rem >= 22'd32) ? '1 : (32'd1 << rem[4:0]) - 32'd1;
        end else begin
          state_d = S_CNT_FIN;
        end
      end
      S_CNT_FIN: begin
        res_cnt_d = 32'(sum_q) << log_zone_size_q;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      scan_q     <= '0;
      rd_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      scan_q     <= scan_d;
      rd_valid_q <= rd_valid_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    mask_q    <= mask_d;
    limit_q   <= limit_d;
    sum_q     <= sum_d;
    pos_q     <= pos_d;
    blk_q     <= blk_d;
    faddr_q   <= faddr_d;
    fbit_q    <= fbit_d;
    res_blk_q <= res_blk_d;
    res_st_q  <= res_st_d;
    res_cnt_q <= res_cnt_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign allocated_block_o = res_blk_q;
  assign status_o          = res_st_q;
  assign free_count_o      = res_cnt_q;

endmodule

### sv/bza_checker.sv
// ----------------------------------------------------------------------------
// bza_checker
// Port-level checks for the bitmap zone allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bza_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  req_type_i,
  input logic        done_o,
  input logic [19:0] allocated_block_o,
  input logic [2:0]  status_o,
  input logic [31:0] free_count_o
);

  // a result word always lands with the block back at idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word while busy");

  a_write_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == bza_pkg::ReqWrite) |=>
      (done_o && status_o == bza_pkg::StOk))
    else $error("word write did not finish next cycle");

  a_long_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i != bza_pkg::ReqWrite) |=> (!done_o && busy))
    else $error("scan request finished too early");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bza_pkg::StOk) |->
      (allocated_block_o == 20'd0 && free_count_o == 32'd0))
    else $error("failed request carries a payload");

endmodule

bind bitmap_zone_allocator_unit bza_checker u_bza_checker (.*);
